@@ rtl/ptc_pkg.sv @@
// shared types and constants of the pressure and temperature compensation block
package ptc_pkg;

    localparam int NUM_STAGES = 11;
    localparam int RAW_W      = 24;
    localparam int COEFF_W    = 16;
    localparam int IN_W       = 2 * RAW_W;
    localparam int RES_W      = 32;
    localparam int OUT_W      = 2 * RES_W;
    localparam int CFG_IDX_W  = 3;

    // 20.00 C in 0.01 C steps
    localparam logic signed [19:0] TEMP_BASE   = 20'sd2000;
    // distance of the -15.00 C band edge below 20.00 C
    localparam logic signed [19:0] FRIGID_EDGE = 20'sd3500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS       = 3'd0,
        REG_OFF        = 3'd1,
        REG_SENS_TEMP  = 3'd2,
        REG_OFF_TEMP   = 3'd3,
        REG_REF_TEMP   = 3'd4,
        REG_TEMP_SLOPE = 3'd5
    } ptc_reg_t;

    typedef struct packed {
        logic [COEFF_W-1:0] sens;
        logic [COEFF_W-1:0] off;
        logic [COEFF_W-1:0] sens_temp;
        logic [COEFF_W-1:0] off_temp;
        logic [COEFF_W-1:0] ref_temp;
        logic [COEFF_W-1:0] temp_slope;
    } ptc_coeff_t;

endpackage

@@ rtl/ptc_cfg_regs.sv @@
// calibration coefficient registers with their write port
module ptc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptc_pkg::COEFF_W-1:0]         cfg_data,
    output ptc_pkg::ptc_coeff_t                 coeff
);
    import ptc_pkg::*;

    ptc_coeff_t coeff_reg;
    ptc_coeff_t coeff_next;

    assign cfg_ready = 1'b1;
    assign coeff     = coeff_reg;

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_valid)
        begin
            case (ptc_reg_t'(cfg_index))
                REG_SENS:       coeff_next.sens       = cfg_data;
                REG_OFF:        coeff_next.off        = cfg_data;
                REG_SENS_TEMP:  coeff_next.sens_temp  = cfg_data;
                REG_OFF_TEMP:   coeff_next.off_temp   = cfg_data;
                REG_REF_TEMP:   coeff_next.ref_temp   = cfg_data;
                REG_TEMP_SLOPE: coeff_next.temp_slope = cfg_data;
                // indexes past the list are dropped
                default:        coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

endmodule

@@ rtl/pressure_temperature_compensation.sv @@
// Second-order pressure and temperature compensation, pipelined over eleven stages.
// A word (raw pressure and raw temperature) is taken every clock while s_tready is
// high, and its result leaves the last stage, which is also the output register.
// Every stage has its own ready, so a held output only stops the words behind it once
// the stages in between are full, and gaps in the stream close up. The pace is one
// word per clock while m_tready is high; the paths that set the stage depth are the
// 25 by 25 bit square of dT and the 24 by 42 bit pressure product, the latter done as
// two 24 by 21 bit halves in one stage and summed in the next. When either raw sample
// is zero, the word comes out with both results zero and the valid flag low.
// Calibration coefficients are written through the cfg port, one per write, and are
// used by the words that follow.
module pressure_temperature_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // raw_pressure [23:0], raw_temperature [47:24]
    input  logic [ptc_pkg::IN_W-1:0]          s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pressure [31:0], temperature [63:32]
    output logic [ptc_pkg::OUT_W-1:0]         m_tdata,
    // valid_res [0]
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptc_pkg::COEFF_W-1:0]       cfg_data
);
    import ptc_pkg::*;

    ptc_coeff_t coeff;

    ptc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeff     (coeff)
    );

    // ---------------------------------------------------------------- flow control
    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES:1]   valid_next;
    logic [NUM_STAGES+1:1] stage_ready;
    logic [NUM_STAGES:0]   valid_in;

    assign valid_in[0] = s_tvalid;
    assign valid_in[NUM_STAGES:1] = valid_reg;
    assign stage_ready[NUM_STAGES+1] = m_tready;

    genvar k;
    generate
        for (k = 1; k <= NUM_STAGES; k++)
        begin : g_flow
            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
            assign valid_next[k]  = stage_ready[k] ? valid_in[k-1] : valid_reg[k];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_ready[1];
    assign m_tvalid = valid_reg[NUM_STAGES];

    // ---------------------------------------------------------------- payload
    logic [RAW_W-1:0]  raw_p;
    logic [RAW_W-1:0]  raw_t;
    assign raw_p = s_tdata[RAW_W-1:0];
    assign raw_t = s_tdata[IN_W-1:RAW_W];

    // stage 1: deviation from the reference temperature
    logic [RAW_W-1:0]   p1_reg, p1_next;
    logic signed [24:0] dt1_reg, dt1_next;
    logic               bad1_reg, bad1_next;

    assign p1_next   = raw_p;
    assign bad1_next = (raw_p == '0) || (raw_t == '0);
    assign dt1_next  = $signed({1'b0, raw_t}) - $signed({1'b0, coeff.ref_temp, 8'b0});

    // stage 2: products with dT
    logic [RAW_W-1:0]   p2_reg;
    logic               bad2_reg;
    logic signed [41:0] mslope2_reg, mslope2_next;
    logic signed [41:0] mtco2_reg, mtco2_next;
    logic signed [41:0] mtcs2_reg, mtcs2_next;
    logic signed [49:0] dtsq_full;
    logic [47:0]        dtsq2_reg, dtsq2_next;

    assign mslope2_next = dt1_reg * $signed({1'b0, coeff.temp_slope});
    assign mtco2_next   = dt1_reg * $signed({1'b0, coeff.off_temp});
    assign mtcs2_next   = dt1_reg * $signed({1'b0, coeff.sens_temp});
    assign dtsq_full    = dt1_reg * dt1_reg;
    assign dtsq2_next   = dtsq_full[47:0];

    // stage 3: first-order terms, both candidate temperature corrections
    logic [RAW_W-1:0]   p3_reg;
    logic               bad3_reg;
    logic signed [18:0] q3_reg, q3_next;
    logic signed [41:0] off3_reg, off3_next;
    logic signed [41:0] sens3_reg, sens3_next;
    logic [16:0]        tilo3_reg, tilo3_next;
    logic [11:0]        tihi3_reg, tihi3_next;
    logic signed [41:0] mslope_adj, mtco_adj, mtcs_adj;
    logic [49:0]        dtsq_x3;

    // signed shifts round toward minus infinity: bias negatives before the shift to round toward zero
    assign mslope_adj = mslope2_reg + (mslope2_reg[41] ? 42'sd8388607 : 42'sd0);
    assign mtco_adj   = mtco2_reg + (mtco2_reg[41] ? 42'sd127 : 42'sd0);
    assign mtcs_adj   = mtcs2_reg + (mtcs2_reg[41] ? 42'sd255 : 42'sd0);
    assign q3_next    = mslope_adj[41:23];
    assign off3_next  = $signed({10'b0, coeff.off, 16'b0})
                      + $signed({{7{mtco_adj[41]}}, mtco_adj[41:7]});
    assign sens3_next = $signed({11'b0, coeff.sens, 15'b0})
                      + $signed({{8{mtcs_adj[41]}}, mtcs_adj[41:8]});
    assign dtsq_x3    = {2'b0, dtsq2_reg} + {1'b0, dtsq2_reg, 1'b0};
    assign tilo3_next = dtsq_x3[49:33];
    assign tihi3_next = dtsq2_reg[47:36];

    // stage 4: band select, squared deviations, temperature result
    logic [RAW_W-1:0]   p4_reg;
    logic               bad4_reg;
    logic signed [41:0] off4_reg, sens4_reg;
    logic signed [19:0] temp4_reg, temp4_next;
    logic [35:0]        devsq4_reg, devsq4_next;
    logic [35:0]        lowsq4_reg, lowsq4_next;
    logic               cold4_reg, cold4_next;
    logic               frigid4_reg, frigid4_next;
    logic signed [19:0] q_ext, low;
    logic signed [37:0] devsq_full;
    logic signed [39:0] lowsq_full;
    logic [16:0]        ti;

    assign q_ext        = {q3_reg[18], q3_reg};
    assign low          = q_ext + FRIGID_EDGE;
    assign cold4_next   = q3_reg[18];
    assign frigid4_next = low[19];
    assign devsq_full   = q3_reg * q3_reg;
    assign lowsq_full   = low * low;
    assign devsq4_next  = devsq_full[35:0];
    assign lowsq4_next  = lowsq_full[35:0];
    assign ti           = cold4_next ? tilo3_reg : {5'b0, tihi3_reg};
    assign temp4_next   = q_ext + TEMP_BASE - $signed({3'b0, ti});

    // stage 5: second-order offset and sensitivity terms
    logic [RAW_W-1:0]   p5_reg;
    logic               bad5_reg;
    logic signed [41:0] off5_reg, sens5_reg;
    logic signed [19:0] temp5_reg;
    logic [39:0]        offi5_reg, offi5_next;
    logic [39:0]        sensi5_reg, sensi5_next;
    logic [36:0]        dev_x3;
    logic [37:0]        dev_x5;
    logic [38:0]        low_x7;

    assign dev_x3 = {1'b0, devsq4_reg} + {devsq4_reg, 1'b0};
    assign dev_x5 = {2'b0, devsq4_reg} + {devsq4_reg, 2'b0};
    assign low_x7 = {lowsq4_reg, 3'b0} - {3'b0, lowsq4_reg};

    always_comb
    begin
        if (cold4_reg)
        begin
            offi5_next  = {4'b0, dev_x3[36:1]} + (frigid4_reg ? {1'b0, low_x7} : 40'd0);
            sensi5_next = {5'b0, dev_x5[37:3]}
                        + (frigid4_reg ? {2'b0, lowsq4_reg, 2'b0} : 40'd0);
        end
        else
        begin
            offi5_next  = {8'b0, devsq4_reg[35:4]};
            sensi5_next = '0;
        end
    end

    // stage 6: corrected offset and sensitivity
    logic [RAW_W-1:0]   p6_reg;
    logic               bad6_reg;
    logic signed [19:0] temp6_reg;
    logic signed [41:0] off6_reg, off6_next;
    logic signed [41:0] sens6_reg, sens6_next;

    assign off6_next  = off5_reg - $signed({2'b0, offi5_reg});
    assign sens6_next = sens5_reg - $signed({2'b0, sensi5_reg});

    // stage 7: pressure product halves
    logic               bad7_reg;
    logic signed [19:0] temp7_reg;
    logic signed [41:0] off7_reg;
    logic [44:0]        pplo7_reg, pplo7_next;
    logic signed [45:0] pphi7_reg, pphi7_next;

    assign pplo7_next = p6_reg * sens6_reg[20:0];
    assign pphi7_next = $signed({1'b0, p6_reg}) * $signed(sens6_reg[41:21]);

    // stage 8: full pressure product
    logic               bad8_reg;
    logic signed [19:0] temp8_reg;
    logic signed [41:0] off8_reg;
    logic signed [63:0] prod8_reg, prod8_next;

    assign prod8_next = $signed({pphi7_reg[42:0], 21'b0}) + $signed({19'b0, pplo7_reg});

    // stage 9: product scaled down
    logic               bad9_reg;
    logic signed [19:0] temp9_reg;
    logic signed [41:0] off9_reg;
    logic signed [42:0] pdiv9_reg, pdiv9_next;
    logic signed [63:0] prod_adj;

    assign prod_adj   = prod8_reg + (prod8_reg[63] ? 64'sd2097151 : 64'sd0);
    assign pdiv9_next = prod_adj[63:21];

    // stage 10: offset removed
    logic               bad10_reg;
    logic signed [19:0] temp10_reg;
    logic signed [43:0] num10_reg, num10_next;

    assign num10_next = {pdiv9_reg[42], pdiv9_reg} - {{2{off9_reg[41]}}, off9_reg};

    // stage 11: output register
    logic [RES_W-1:0]   pres11_reg, pres11_next;
    logic [RES_W-1:0]   temp11_reg, temp11_next;
    logic               vres11_reg, vres11_next;
    logic signed [43:0] num_adj;

    assign num_adj     = num10_reg + (num10_reg[43] ? 44'sd8191 : 44'sd0);
    assign pres11_next = bad10_reg ? '0 : {num_adj[43], num_adj[43:13]};
    assign temp11_next = bad10_reg ? '0 : {{12{temp10_reg[19]}}, temp10_reg};
    assign vres11_next = !bad10_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            p1_reg   <= p1_next;
            dt1_reg  <= dt1_next;
            bad1_reg <= bad1_next;
        end
        if (stage_ready[2])
        begin
            p2_reg      <= p1_reg;
            bad2_reg    <= bad1_reg;
            mslope2_reg <= mslope2_next;
            mtco2_reg   <= mtco2_next;
            mtcs2_reg   <= mtcs2_next;
            dtsq2_reg   <= dtsq2_next;
        end
        if (stage_ready[3])
        begin
            p3_reg    <= p2_reg;
            bad3_reg  <= bad2_reg;
            q3_reg    <= q3_next;
            off3_reg  <= off3_next;
            sens3_reg <= sens3_next;
            tilo3_reg <= tilo3_next;
            tihi3_reg <= tihi3_next;
        end
        if (stage_ready[4])
        begin
            p4_reg      <= p3_reg;
            bad4_reg    <= bad3_reg;
            off4_reg    <= off3_reg;
            sens4_reg   <= sens3_reg;
            temp4_reg   <= temp4_next;
            devsq4_reg  <= devsq4_next;
            lowsq4_reg  <= lowsq4_next;
            cold4_reg   <= cold4_next;
            frigid4_reg <= frigid4_next;
        end
        if (stage_ready[5])
        begin
            p5_reg     <= p4_reg;
            bad5_reg   <= bad4_reg;
            off5_reg   <= off4_reg;
            sens5_reg  <= sens4_reg;
            temp5_reg  <= temp4_reg;
            offi5_reg  <= offi5_next;
            sensi5_reg <= sensi5_next;
        end
        if (stage_ready[6])
        begin
            p6_reg    <= p5_reg;
            bad6_reg  <= bad5_reg;
            temp6_reg <= temp5_reg;
            off6_reg  <= off6_next;
            sens6_reg <= sens6_next;
        end
        if (stage_ready[7])
        begin
            bad7_reg  <= bad6_reg;
            temp7_reg <= temp6_reg;
            off7_reg  <= off6_reg;
            pplo7_reg <= pplo7_next;
            pphi7_reg <= pphi7_next;
        end
        if (stage_ready[8])
        begin
            bad8_reg  <= bad7_reg;
            temp8_reg <= temp7_reg;
            off8_reg  <= off7_reg;
            prod8_reg <= prod8_next;
        end
        if (stage_ready[9])
        begin
            bad9_reg  <= bad8_reg;
            temp9_reg <= temp8_reg;
            off9_reg  <= off8_reg;
            pdiv9_reg <= pdiv9_next;
        end
        if (stage_ready[10])
        begin
            bad10_reg  <= bad9_reg;
            temp10_reg <= temp9_reg;
            num10_reg  <= num10_next;
        end
        if (stage_ready[11])
        begin
            pres11_reg <= pres11_next;
            temp11_reg <= temp11_next;
            vres11_reg <= vres11_next;
        end
    end

    assign m_tdata = {temp11_reg, pres11_reg};
    assign m_tuser = vres11_reg;

    // ---------------------------------------------------------------- checks
    // a failed read leaves both results cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed-read word carries nonzero results");

    // an empty output register means the whole pipe can take a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input held off with an empty output register");

    // an accepted word shows up in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[1])
        else $error("accepted word lost at pipe entry");

    // compensated temperature stays within the 20-bit band range
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            ((m_tdata[63:51] == 13'h0000) || (m_tdata[63:51] == 13'h1fff)))
        else $error("temperature result out of range");

endmodule
